// ----- sv/drmq_pkg.sv -----
`default_nettype none
package drmq_pkg;
   typedef struct packed {
      logic signed [15:0] x1;
      logic signed [15:0] y1;
      logic signed [15:0] x2;
      logic signed [15:0] y2;
   } rect_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_APPEND,
      ST_CP_SRC_RD,
      ST_CP_SRC_LD,
      ST_CP_DST_RD,
      ST_CP_DST_CHK,
      ST_SH_RD,
      ST_SH_WR,
      ST_DR_RD,
      ST_DR_OUT
   } state_type;

   typedef enum logic [1:0] {
      ADDR_SCAN,
      ADDR_SRC,
      ADDR_SHIFT
   } addr_sel_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_NEW,
      WR_JOIN_NEW,
      WR_JOIN_SRC,
      WR_SHIFT
   } wr_sel_type;

   typedef struct packed {
      logic         load_new;
      logic         load_src;
      addr_sel_type addr_sel;
      wr_sel_type   wr_sel;
      logic         out_load;
   } cmd_type;

   typedef struct packed {
      logic overlap_new;
      logic overlap_src;
   } status_type;

   function automatic logic overlaps(rect_type a, rect_type b);
      logic signed [15:0] lx, ly, hx, hy;
      lx = (a.x1 > b.x1) ? a.x1 : b.x1;
      ly = (a.y1 > b.y1) ? a.y1 : b.y1;
      hx = (a.x2 < b.x2) ? a.x2 : b.x2;
      hy = (a.y2 < b.y2) ? a.y2 : b.y2;
      return (lx <= hx) && (ly <= hy);
   endfunction

   function automatic rect_type join_rect(rect_type a, rect_type b);
      rect_type c;
      c.x1 = (a.x1 < b.x1) ? a.x1 : b.x1;
      c.y1 = (a.y1 < b.y1) ? a.y1 : b.y1;
      c.x2 = (a.x2 > b.x2) ? a.x2 : b.x2;
      c.y2 = (a.y2 > b.y2) ? a.y2 : b.y2;
      return c;
   endfunction
endpackage
`default_nettype wire

// ----- sv/drmq_datapath.sv -----
`default_nettype none
module drmq_datapath #(
   parameter int DEPTH = 32,
   parameter int AW = 5
) (
   input  wire                   clock,
   input  drmq_pkg::cmd_type     cmd,
   input  wire [AW-1:0]          idx,
   input  wire [AW-1:0]          src,
   input  drmq_pkg::rect_type    in_rect,
   output drmq_pkg::status_type  status,
   output drmq_pkg::rect_type    out_rect
);
   drmq_pkg::rect_type mem [DEPTH];
   drmq_pkg::rect_type rd_ff;
   drmq_pkg::rect_type new_ff, src_ff, out_ff;
   logic [AW-1:0] addr, wa;
   drmq_pkg::rect_type wd;

   always_comb begin
      case (cmd.addr_sel)
         drmq_pkg::ADDR_SCAN:  addr = idx;
         drmq_pkg::ADDR_SRC:   addr = AW'(src - 1'b1);
         drmq_pkg::ADDR_SHIFT: addr = AW'(idx + 1'b1);
         default:              addr = idx;
      endcase
      wa = idx;
      case (cmd.wr_sel)
         drmq_pkg::WR_NEW:      wd = new_ff;
         drmq_pkg::WR_JOIN_NEW: wd = drmq_pkg::join_rect(rd_ff, new_ff);
         drmq_pkg::WR_JOIN_SRC: wd = drmq_pkg::join_rect(rd_ff, src_ff);
         drmq_pkg::WR_SHIFT:    wd = rd_ff;
         default:               wd = rd_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[addr];
      if (cmd.wr_sel != drmq_pkg::WR_NONE) begin
         mem[wa] <= wd;
      end
      if (cmd.load_new) begin
         new_ff <= in_rect;
      end
      if (cmd.load_src) begin
         src_ff <= rd_ff;
      end
      if (cmd.out_load) begin
         out_ff <= rd_ff;
      end
   end

   assign status.overlap_new = drmq_pkg::overlaps(rd_ff, new_ff);
   assign status.overlap_src = drmq_pkg::overlaps(rd_ff, src_ff);
   assign out_rect = out_ff;
endmodule
`default_nettype wire

// ----- sv/drmq_control.sv -----
`default_nettype none
module drmq_control #(
   parameter int DEPTH = 32,
   parameter int AW = 5,
   parameter int CW = 6
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  wire                  req_op,
   input  wire                  req_empty,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output logic                 rsp_last,
   input  drmq_pkg::status_type status,
   output drmq_pkg::cmd_type    cmd,
   output logic [AW-1:0]        idx,
   output logic [AW-1:0]        src
);
   drmq_pkg::state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in, i_ff, i_in, s_ff, s_in;
   logic vld_ff, vld_in, last_ff, last_in;

   assign idx = i_ff[AW-1:0];
   assign src = s_ff[AW-1:0];
   assign rsp_tvalid = vld_ff;
   assign rsp_last = last_ff;
   assign req_tready = (state_ff == drmq_pkg::ST_IDLE) && !vld_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      i_in = i_ff;
      s_in = s_ff;
      vld_in = vld_ff && !rsp_tready;
      last_in = last_ff;
      case (state_ff)
         drmq_pkg::ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               i_in = '0;
               if (req_op) begin
                  if (cnt_ff != '0) state_in = drmq_pkg::ST_DR_RD;
               end else if (!req_empty) begin
                  state_in = (cnt_ff == '0) ? drmq_pkg::ST_APPEND : drmq_pkg::ST_SCAN_RD;
               end
            end
         end
         drmq_pkg::ST_SCAN_RD: state_in = drmq_pkg::ST_SCAN_CHK;
         drmq_pkg::ST_SCAN_CHK: begin
            if (status.overlap_new) begin
               s_in = cnt_ff;
               state_in = drmq_pkg::ST_CP_SRC_RD;
            end else if (i_ff + 1'b1 < cnt_ff) begin
               i_in = i_ff + 1'b1;
               state_in = drmq_pkg::ST_SCAN_RD;
            end else if (cnt_ff < CW'(DEPTH)) begin
               i_in = cnt_ff;
               state_in = drmq_pkg::ST_APPEND;
            end else begin
               s_in = cnt_ff;
               state_in = drmq_pkg::ST_CP_SRC_RD;
            end
         end
         drmq_pkg::ST_APPEND: begin
            cnt_in = cnt_ff + 1'b1;
            state_in = drmq_pkg::ST_IDLE;
         end
         drmq_pkg::ST_CP_SRC_RD: begin
            if (s_ff == '0) begin
               state_in = drmq_pkg::ST_IDLE;
            end else begin
               s_in = s_ff - 1'b1;
               state_in = drmq_pkg::ST_CP_SRC_LD;
            end
         end
         drmq_pkg::ST_CP_SRC_LD: begin
            if (s_ff >= cnt_ff) begin
               state_in = drmq_pkg::ST_CP_SRC_RD;
            end else begin
               i_in = '0;
               state_in = drmq_pkg::ST_CP_DST_RD;
            end
         end
         drmq_pkg::ST_CP_DST_RD: begin
            if (i_ff == s_ff) begin
               i_in = i_ff + 1'b1;
               if (i_ff + 1'b1 >= cnt_ff) state_in = drmq_pkg::ST_CP_SRC_RD;
            end else begin
               state_in = drmq_pkg::ST_CP_DST_CHK;
            end
         end
         drmq_pkg::ST_CP_DST_CHK: begin
            if (status.overlap_src) begin
               i_in = s_ff;
               state_in = (s_ff + 1'b1 < cnt_ff) ? drmq_pkg::ST_SH_RD : drmq_pkg::ST_SH_WR;
            end else if (i_ff + 1'b1 < cnt_ff) begin
               i_in = i_ff + 1'b1;
               state_in = drmq_pkg::ST_CP_DST_RD;
            end else begin
               state_in = drmq_pkg::ST_CP_SRC_RD;
            end
         end
         drmq_pkg::ST_SH_RD: state_in = drmq_pkg::ST_SH_WR;
         drmq_pkg::ST_SH_WR: begin
            if (i_ff + 2'd2 < cnt_ff) begin
               i_in = i_ff + 1'b1;
               state_in = drmq_pkg::ST_SH_RD;
            end else begin
               cnt_in = cnt_ff - 1'b1;
               state_in = drmq_pkg::ST_CP_SRC_RD;
            end
         end
         drmq_pkg::ST_DR_RD: begin
            if (!vld_ff || rsp_tready) state_in = drmq_pkg::ST_DR_OUT;
         end
         drmq_pkg::ST_DR_OUT: begin
            vld_in = 1'b1;
            last_in = (i_ff + 1'b1 == cnt_ff);
            if (i_ff + 1'b1 == cnt_ff) begin
               cnt_in = '0;
               state_in = drmq_pkg::ST_IDLE;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = drmq_pkg::ST_DR_RD;
            end
         end
         default: state_in = drmq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.addr_sel = drmq_pkg::ADDR_SCAN;
      cmd.wr_sel = drmq_pkg::WR_NONE;
      case (state_ff)
         drmq_pkg::ST_IDLE: cmd.load_new = req_tvalid && req_tready;
         drmq_pkg::ST_SCAN_CHK: begin
            if (status.overlap_new || (i_ff + 1'b1 >= cnt_ff && cnt_ff == CW'(DEPTH)))
               cmd.wr_sel = drmq_pkg::WR_JOIN_NEW;
         end
         drmq_pkg::ST_APPEND: begin
            cmd.addr_sel = drmq_pkg::ADDR_SCAN;
            cmd.wr_sel = drmq_pkg::WR_NEW;
         end
         drmq_pkg::ST_CP_SRC_RD: cmd.addr_sel = drmq_pkg::ADDR_SRC;
         drmq_pkg::ST_CP_SRC_LD: cmd.load_src = 1'b1;
         drmq_pkg::ST_CP_DST_CHK: begin
            if (status.overlap_src) cmd.wr_sel = drmq_pkg::WR_JOIN_SRC;
         end
         drmq_pkg::ST_SH_RD: cmd.addr_sel = drmq_pkg::ADDR_SHIFT;
         drmq_pkg::ST_SH_WR: begin
            if (i_ff + 1'b1 < cnt_ff) cmd.wr_sel = drmq_pkg::WR_SHIFT;
            cmd.addr_sel = drmq_pkg::ADDR_SHIFT;
         end
         drmq_pkg::ST_DR_OUT: cmd.out_load = 1'b1;
         default: cmd.addr_sel = drmq_pkg::ADDR_SCAN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= drmq_pkg::ST_IDLE;
         cnt_ff <= '0;
         i_ff <= '0;
         s_ff <= '0;
         vld_ff <= 1'b0;
         last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         i_ff <= i_in;
         s_ff <= s_in;
         vld_ff <= vld_in;
         last_ff <= last_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset) cnt_ff <= CW'(DEPTH))
      else $error("entry count above depth");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == drmq_pkg::ST_IDLE)
      else $error("ready outside idle");
   a_drain_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == drmq_pkg::ST_DR_OUT && state_in == drmq_pkg::ST_IDLE) |=> cnt_ff == '0)
      else $error("drain left entries");
endmodule
`default_nettype wire

// ----- sv/dirty_rect_merge_queue_top.sv -----
// Queue item: each stored entry is read and checked for overlap in turn; with no overlap the item is appended,
// or merged into the last entry when the list is full. A merge starts a compaction pass that folds overlapping entries.
// Drain: each entry is read and then loaded into the output register; the receiver can hold off the drain.
// One item is handled at a time; ready is high only while idle with no word waiting.
// Synchronous reset empties the list; entry contents stay undefined until written.
`default_nettype none
module dirty_rect_merge_queue_top #(
   parameter int DEPTH = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [63:0] req_tdata,  // min_x, min_y, max_x, max_y
   input  wire         req_tuser,  // op
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [63:0] rsp_tdata,  // out_min_x, out_min_y, out_max_x, out_max_y
   output logic        rsp_tlast   // is_last
);
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   drmq_pkg::rect_type in_rect, out_rect;
   drmq_pkg::cmd_type cmd;
   drmq_pkg::status_type status;
   logic [AW-1:0] idx, src;
   logic empty;

   assign in_rect.x1 = req_tdata[15:0];
   assign in_rect.y1 = req_tdata[31:16];
   assign in_rect.x2 = req_tdata[47:32];
   assign in_rect.y2 = req_tdata[63:48];
   assign empty = (in_rect.x2 < in_rect.x1) || (in_rect.y2 < in_rect.y1);

   drmq_control #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .req_op(req_tuser), .req_empty(empty),
      .rsp_tvalid, .rsp_tready, .rsp_last(rsp_tlast), .status, .cmd, .idx, .src
   );

   drmq_datapath #(.DEPTH(DEPTH), .AW(AW)) u_dp (
      .clock, .cmd, .idx, .src, .in_rect, .status, .out_rect
   );

   assign rsp_tdata = {out_rect.y2, out_rect.x2, out_rect.y1, out_rect.x1};
endmodule
`default_nettype wire

// ----- sim/dirty_rect_merge_queue_top_test.sv -----
`default_nettype none
module dirty_rect_merge_queue_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 32;
   localparam int STALL_LIMIT = 200000;
   localparam bit OP_QUEUE = 1'b0;
   localparam bit OP_DRAIN = 1'b1;

   typedef struct packed {
      logic [15:0] y2;
      logic [15:0] x2;
      logic [15:0] y1;
      logic [15:0] x1;
   } edges_word_type;

   typedef struct {
      logic [15:0] x1, y1, x2, y2;
      logic        last;
   } dirty_word_type;

   class dirty_scoreboard;
      logic signed [15:0] lo_x[DEPTH], lo_y[DEPTH], hi_x[DEPTH], hi_y[DEPTH];
      int                 count;
      dirty_word_type     pending[$];
      int                 errors;

      function bit hits(int a, logic signed [15:0] bx1, logic signed [15:0] by1,
                        logic signed [15:0] bx2, logic signed [15:0] by2);
         logic signed [15:0] lx, ly, hx, hy;
         lx = lo_x[a] > bx1 ? lo_x[a] : bx1;
         ly = lo_y[a] > by1 ? lo_y[a] : by1;
         hx = hi_x[a] < bx2 ? hi_x[a] : bx2;
         hy = hi_y[a] < by2 ? hi_y[a] : by2;
         return lx <= hx && ly <= hy;
      endfunction

      function void grow(int a, logic signed [15:0] bx1, logic signed [15:0] by1,
                         logic signed [15:0] bx2, logic signed [15:0] by2);
         if (bx1 < lo_x[a]) lo_x[a] = bx1;
         if (by1 < lo_y[a]) lo_y[a] = by1;
         if (bx2 > hi_x[a]) hi_x[a] = bx2;
         if (by2 > hi_y[a]) hi_y[a] = by2;
      endfunction

      function void fold_back();
         for (int i = count; i > 0; i--) begin
            int s;
            s = i - 1;
            if (s >= count) continue;
            for (int j = 0; j < count; j++) begin
               if (j == s) continue;
               if (hits(j, lo_x[s], lo_y[s], hi_x[s], hi_y[s])) begin
                  grow(j, lo_x[s], lo_y[s], hi_x[s], hi_y[s]);
                  for (int k = s; k + 1 < count; k++) begin
                     lo_x[k] = lo_x[k+1]; lo_y[k] = lo_y[k+1];
                     hi_x[k] = hi_x[k+1]; hi_y[k] = hi_y[k+1];
                  end
                  count--;
                  break;
               end
            end
         end
      endfunction

      function void note_input(bit op, edges_word_type e);
         logic signed [15:0] x1, y1, x2, y2;
         dirty_word_type w;
         x1 = e.x1; y1 = e.y1; x2 = e.x2; y2 = e.y2;
         if (op == OP_DRAIN) begin
            for (int i = 0; i < count; i++) begin
               w.x1 = lo_x[i]; w.y1 = lo_y[i]; w.x2 = hi_x[i]; w.y2 = hi_y[i];
               w.last = (i == count - 1);
               pending.push_back(w);
            end
            count = 0;
            return;
         end
         if (x2 < x1 || y2 < y1) return;
         for (int i = 0; i < count; i++)
            if (hits(i, x1, y1, x2, y2)) begin
               grow(i, x1, y1, x2, y2);
               fold_back();
               return;
            end
         if (count < DEPTH) begin
            lo_x[count] = x1; lo_y[count] = y1; hi_x[count] = x2; hi_y[count] = y2;
            count++;
         end else begin
            grow(DEPTH - 1, x1, y1, x2, y2);
            fold_back();
         end
      endfunction

      function void check_output(edges_word_type d, logic last);
         dirty_word_type w;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word %h last %b", $time, d, last);
            errors++;
            return;
         end
         w = pending.pop_front();
         if (d.x1 !== w.x1 || d.y1 !== w.y1 || d.x2 !== w.x2 || d.y2 !== w.y2
             || last !== w.last) begin
            $display("%0t: expected %h %h %h %h last %b, got %h %h %h %h last %b", $time,
                     w.x1, w.y1, w.x2, w.y2, w.last, d.x1, d.y1, d.x2, d.y2, last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;

   dirty_scoreboard board = new();
   int  hold_off = 0;
   int  idle_cycles = 0;
   bit  stimulus_done = 1'b0;

   dirty_rect_merge_queue_top #(.DEPTH(DEPTH)) u_top (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) board.note_input(req_tuser, req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) board.check_output(rsp_tdata, rsp_tlast);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_off > 0) begin
         rsp_tready <= 1'b0;
         hold_off <= hold_off - 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 3) != 0) || stimulus_done;
      end
   end

   task automatic send_word(bit op, logic [15:0] x1, logic [15:0] y1,
                            logic [15:0] x2, logic [15:0] y2);
      edges_word_type e;
      e.x1 = x1; e.y1 = y1; e.x2 = x2; e.y2 = y2;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= e;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic pause_sender(int n);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic send_random_rect(int span);
      logic [15:0] x, y;
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) begin
         send_word(OP_QUEUE, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
         x = 16'($urandom_range(0, 400) - 200);
         y = 16'($urandom_range(0, 400) - 200);
         if (r == 1) x = x ^ 16'h8000;
         send_word(OP_QUEUE, x, y, 16'(x + $urandom_range(0, span)),
                   16'(y + $urandom_range(0, span)));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_word(OP_DRAIN, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
      send_word(OP_QUEUE, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
      send_word(OP_DRAIN, 0, 0, 0, 0);
      send_word(OP_QUEUE, 10, 10, 9, 20);
      send_word(OP_QUEUE, 10, 10, 20, 9);
      send_word(OP_QUEUE, 0, 0, 9, 9);
      send_word(OP_QUEUE, 10, 0, 19, 9);
      send_word(OP_QUEUE, 0, 10, 9, 19);
      send_word(OP_QUEUE, 9, 9, 10, 10);
      send_word(OP_QUEUE, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_word(OP_QUEUE, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_word(OP_DRAIN, 16'h1234, 0, 0, 0);
      for (int i = 0; i < DEPTH + 2; i++)
         send_word(OP_QUEUE, 16'(i * 4), 0, 16'(i * 4 + 1), 1);
      pause_sender(2);
      send_word(OP_DRAIN, 0, 0, 0, 0);
      send_word(OP_QUEUE, 0, 0, 3, 3);
      send_word(OP_QUEUE, 50, 50, 53, 53);
      send_word(OP_QUEUE, 100, 0, 103, 3);
      send_word(OP_QUEUE, 0, 0, 200, 200);
      send_word(OP_DRAIN, 0, 0, 0, 0);
      for (int n = 0; n < 135; n++) begin
         if (n == 60) begin
            hold_off <= 3000;
            for (int k = 0; k < 8; k++) begin
               for (int m = 0; m < 3; m++) send_random_rect(30);
               send_word(OP_DRAIN, 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom));
            end
         end
         if (n == 120) begin
            req_tvalid <= 1'b0;
            while (board.pending.size() != 0) @(posedge clock);
         end
         if ($urandom_range(0, 11) == 0)
            send_word(OP_DRAIN, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom));
         else
            send_random_rect(n % 40 < 20 ? 20 : 120);
         if (n % 50 > 25 && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 12));
      end
      send_word(OP_DRAIN, 0, 0, 0, 0);
      req_tvalid <= 1'b0;
      stimulus_done <= 1'b1;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ----- sim.f -----
sv/drmq_pkg.sv
sv/drmq_datapath.sv
sv/drmq_control.sv
sv/dirty_rect_merge_queue_top.sv
sim/dirty_rect_merge_queue_top_test.sv
